/* rtl/core/touch_to_source_mapper_unit_defines.svh */
// Assertion helpers shared by the mapper RTL.
`ifndef TOUCH_TO_SOURCE_MAPPER_UNIT_DEFINES_SVH
`define TOUCH_TO_SOURCE_MAPPER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TSM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TSM_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSM_ASSERT(label, clk, rst, prop, msg)
`define TSM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/core/tsm_pkg.sv */
package tsm_pkg;
   localparam int CoordW = 11;
   localparam int TouchW = 8;
   localparam int QuotW = 22;
   localparam int DivSteps = QuotW;
   localparam int DefScreenW = 256;
   localparam int DefScreenH = 192;

   typedef enum logic [1:0] {
      REG_SRC_W = 2'd0,
      REG_SRC_H = 2'd1,
      REG_MODE  = 2'd2
   } reg_idx_type;

   // view_mode codes; world map, pip view and unused codes fit the full source
   typedef enum logic [3:0] {
      MODE_FULL      = 4'd0,
      MODE_MAIN_MENU = 4'd1,
      MODE_FIELD     = 4'd2,
      MODE_GUI       = 4'd3,
      MODE_DIALOG    = 4'd4,
      MODE_INVENTORY = 4'd5,
      MODE_CHARACTER = 4'd6,
      MODE_LOAD_SAVE = 4'd7,
      MODE_WORLD_MAP = 4'd8,
      MODE_PIP_VIEW  = 4'd9
   } view_mode_type;

   // one division in flight through the cell chain
   typedef struct packed {
      logic              vld;
      logic [QuotW-1:0]  rem;   // partial remainder
      logic [QuotW-1:0]  num;   // remaining numerator bits, MSB first
      logic [QuotW-1:0]  quo;
      logic [QuotW-1:0]  den;
      logic [CoordW-1:0] base;  // added after the divide
   } div_cell_type;
endpackage

/* rtl/core/tsm_div_cell.sv */
module tsm_div_cell
   import tsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_cell_type cell_i,
   output div_cell_type cell_o
);
   div_cell_type cell_ff, cell_in;
   logic [QuotW:0] trial;

   // one restoring step: shift in a numerator bit, try to subtract
   always_comb begin
      trial = {cell_i.rem, cell_i.num[QuotW-1]};
      cell_in = cell_i;
      cell_in.num = {cell_i.num[QuotW-2:0], 1'b0};
      if (trial >= {1'b0, cell_i.den}) begin
         cell_in.rem = QuotW'(trial - {1'b0, cell_i.den});
         cell_in.quo = {cell_i.quo[QuotW-2:0], 1'b1};
      end else begin
         cell_in.rem = trial[QuotW-1:0];
         cell_in.quo = {cell_i.quo[QuotW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else begin
         cell_ff.vld <= cell_i.vld;
      end
      cell_ff.rem  <= cell_in.rem;
      cell_ff.num  <= cell_in.num;
      cell_ff.quo  <= cell_in.quo;
      cell_ff.den  <= cell_in.den;
      cell_ff.base <= cell_in.base;
   end
   assign cell_o = cell_ff;
endmodule

/* rtl/core/tsm_div_chain.sv */
module tsm_div_chain
   import tsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_cell_type      head_i,
   output logic              vld_o,
   output logic [CoordW-1:0] res_o
);
   div_cell_type link [DivSteps+1];
   logic [QuotW-1:0] sum;

   assign link[0] = head_i;
   for (genvar g = 0; g < DivSteps; g++) begin : g_cell
      tsm_div_cell u_cell (.clock(clock), .reset(reset), .cell_i(link[g]),
         .cell_o(link[g+1]));
   end

   assign sum = link[DivSteps].quo + QuotW'(link[DivSteps].base);
   assign vld_o = link[DivSteps].vld;
   assign res_o = sum[CoordW-1:0];
endmodule

/* rtl/core/touch_to_source_mapper_unit.sv */
// Touch-to-source mapper.
// req_ carries one touch word: tdata[7:0] screen_x, [15:8] screen_y.
// rsp_ returns one mapped word per touch: tdata[10:0] mapped_x,
// [21:11] mapped_y (zero padded to 24 bits).
// csr_ writes source_width (0), source_height (1), view_mode (2); other
// indexes drop. Write only while idle.
// Datapath: a clamp stage and a multiply stage, then a chain of 22
// restoring divide cells (one quotient bit each), then the output
// FIFO register. Both axes run through twin chains that accept a
// new word every cycle, so throughput is one word per cycle while
// req_tready is high. The chain has no stall of its own: a credit
// count of 32 limits words in flight to the output FIFO depth, so a
// stalled receiver holds results in the FIFO and req_tready falls
// once credits run out. Whenever the fitted source size changes, a
// serial divider recomputes the fitted view; req_tready stays low
// meanwhile. Reset restores 640x480, mode 0, empties the pipeline
// and FIFO, and starts that fit before the first touch is taken.
module touch_to_source_mapper_unit
   import tsm_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DefScreenW,
   parameter int SCREEN_HEIGHT = DefScreenH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // screen_x, screen_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // mapped_x, mapped_y, pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
`include "touch_to_source_mapper_unit_defines.svh"
   localparam int Depth = 32;
   localparam int PtrW = $clog2(Depth);

   logic [CoordW-1:0] src_w_ff, src_h_ff;
   logic [3:0] mode_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= CoordW'(640);
         src_h_ff <= CoordW'(480);
         mode_ff  <= MODE_FULL;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SRC_W: src_w_ff <= csr_data;
            REG_SRC_H: src_h_ff <= csr_data;
            REG_MODE:  mode_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // ---- view: from registers (user-held while busy, unenforced) ----
   logic [QuotW-1:0] fw_div, fh_div;
   logic [CoordW-1:0] wcl, hcl;
   logic [CoordW-1:0] sx, sy, sw, sh;
   logic [CoordW-1:0] dx, dy, dw, dh;
   logic [CoordW-1:0] fx_sw, fx_sh;

   assign wcl = (src_w_ff < CoordW'(64)) ? CoordW'(64) : src_w_ff;
   assign hcl = (src_h_ff < CoordW'(64)) ? CoordW'(64) : src_h_ff;

   always_comb begin
      sx = '0; sy = '0; fx_sw = wcl; fx_sh = hcl;
      unique case (mode_ff)
         MODE_FIELD: begin fx_sw = 11'd400; fx_sh = 11'd240; end
         MODE_GUI: begin sy = 11'd359; fx_sw = 11'd640; fx_sh = 11'd121; end
         MODE_DIALOG: begin
            sx = 11'd145; sy = 11'd320; fx_sw = 11'd345; fx_sh = 11'd160;
         end
         MODE_INVENTORY: begin
            sx = 11'd95; sy = 11'd10; fx_sw = 11'd470; fx_sh = 11'd357;
         end
         MODE_CHARACTER: begin
            sx = 11'd10; sy = 11'd30; fx_sw = 11'd625; fx_sh = 11'd420;
         end
         MODE_LOAD_SAVE: begin
            sx = 11'd20; sy = 11'd20; fx_sw = 11'd600; fx_sh = 11'd440;
         end
         MODE_MAIN_MENU: begin
            sx = 11'd400; sy = 11'd25; fx_sw = 11'd215; fx_sh = 11'd230;
         end
         default: ;
      endcase
      sw = fx_sw;
      sh = fx_sh;
   end

   // Fitted sizes need a divide by the source size; a small sequential
   // divider reruns whenever the fitted source size sw or sh changes.
   logic [QuotW-1:0] fwq_ff, fhq_ff, rem_ff, num_ff, den_ff;
   logic [4:0] cnt_ff;
   logic phase_ff, fit_ok_ff;
   logic [CoordW-1:0] lw_ff, lh_ff;
   logic chg;
   logic [QuotW:0] tr;
   assign chg = (lw_ff != sw) || (lh_ff != sh);
   assign tr = {rem_ff, num_ff[QuotW-1]};
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_ok_ff <= 1'b0;
         cnt_ff <= '0;
         phase_ff <= 1'b0;
         lw_ff <= '0;
         lh_ff <= '0;
      end else if (chg) begin
         lw_ff <= sw; lh_ff <= sh;
         fit_ok_ff <= 1'b0;
         phase_ff <= 1'b0;
         cnt_ff <= 5'(QuotW);
         rem_ff <= '0;
         num_ff <= QuotW'(sw * SCREEN_HEIGHT);
         den_ff <= QuotW'(sh);
      end else if (cnt_ff != '0) begin
         num_ff <= {num_ff[QuotW-2:0], 1'b0};
         if (tr >= {1'b0, den_ff}) begin
            rem_ff <= QuotW'(tr - {1'b0, den_ff});
            fwq_ff <= {fwq_ff[QuotW-2:0], 1'b1};
         end else begin
            rem_ff <= tr[QuotW-1:0];
            fwq_ff <= {fwq_ff[QuotW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 5'd1;
      end else if (!phase_ff) begin
         fhq_ff <= fwq_ff;
         phase_ff <= 1'b1;
         cnt_ff <= 5'(QuotW);
         rem_ff <= '0;
         num_ff <= QuotW'(sh * SCREEN_WIDTH);
         den_ff <= QuotW'(sw);
      end else begin
         fit_ok_ff <= 1'b1;
      end
   end
   // after phase 1: fhq_ff holds w*H/h, fwq_ff holds h*W/w
   assign fw_div = fhq_ff;
   assign fh_div = fwq_ff;

   always_comb begin
      if (mode_ff == MODE_MAIN_MENU) begin
         dx = 11'd34; dy = '0; dw = 11'd187; dh = 11'd192;
      end else begin
         dw = (fw_div > QuotW'(SCREEN_WIDTH)) ? CoordW'(SCREEN_WIDTH)
                                               : fw_div[CoordW-1:0];
         dh = (fh_div > QuotW'(SCREEN_HEIGHT)) ? CoordW'(SCREEN_HEIGHT)
                                                : fh_div[CoordW-1:0];
         dx = CoordW'((CoordW'(SCREEN_WIDTH) - dw) >> 1);
         dy = CoordW'((CoordW'(SCREEN_HEIGHT) - dh) >> 1);
      end
   end

   // ---- credit flow ----
   logic [PtrW:0] cred_ff;
   logic acc, pop, done_x;
   assign req_tready = fit_ok_ff && !chg && (cred_ff != '0);
   assign acc = req_tvalid && req_tready;

   // ---- stage 1: clamp; stage 2: multiply ----
   logic [CoordW-1:0] px, py, hx, hy;
   logic v1_ff;
   logic [CoordW-1:0] ox_ff, oy_ff;
   logic [CoordW-1:0] sw1_ff, sh1_ff, sx1_ff, sy1_ff, dw1_ff, dh1_ff;
   assign hx = dx + dw - CoordW'(1);
   assign hy = dy + dh - CoordW'(1);
   always_comb begin
      px = CoordW'(req_tdata[7:0]);
      py = CoordW'(req_tdata[15:8]);
      if (px < dx) px = dx;
      if (px > hx) px = hx;
      if (py < dy) py = dy;
      if (py > hy) py = hy;
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= acc;
      ox_ff <= px - dx; oy_ff <= py - dy;
      sw1_ff <= sw; sh1_ff <= sh; sx1_ff <= sx; sy1_ff <= sy;
      dw1_ff <= dw; dh1_ff <= dh;
   end

   div_cell_type hx_ff, hy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         hx_ff.vld <= 1'b0; hy_ff.vld <= 1'b0;
      end else begin
         hx_ff.vld <= v1_ff; hy_ff.vld <= v1_ff;
      end
      hx_ff.rem <= '0; hy_ff.rem <= '0;
      hx_ff.quo <= '0; hy_ff.quo <= '0;
      hx_ff.num <= QuotW'(ox_ff) * QuotW'(sw1_ff);
      hy_ff.num <= QuotW'(oy_ff) * QuotW'(sh1_ff);
      hx_ff.den <= QuotW'(dw1_ff); hy_ff.den <= QuotW'(dh1_ff);
      hx_ff.base <= sx1_ff; hy_ff.base <= sy1_ff;
   end

   logic done_y;
   logic [CoordW-1:0] mx, my;
   tsm_div_chain u_chain_x (.clock(clock), .reset(reset), .head_i(hx_ff),
      .vld_o(done_x), .res_o(mx));
   tsm_div_chain u_chain_y (.clock(clock), .reset(reset), .head_i(hy_ff),
      .vld_o(done_y), .res_o(my));

   // ---- output FIFO ----
   logic [2*CoordW-1:0] fifo_ff [Depth];
   logic [PtrW-1:0] wp_ff, rp_ff;
   logic [PtrW:0] cnt_q_ff;
   assign rsp_tvalid = cnt_q_ff != '0;
   assign pop = rsp_tvalid && rsp_tready;
   assign rsp_tdata = {2'd0, fifo_ff[rp_ff]};
   always_ff @(posedge clock) begin
      if (done_x) fifo_ff[wp_ff] <= {my, mx};
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_q_ff <= '0;
         cred_ff <= (PtrW+1)'(Depth);
      end else begin
         if (done_x) wp_ff <= wp_ff + PtrW'(1);
         if (pop) rp_ff <= rp_ff + PtrW'(1);
         cnt_q_ff <= cnt_q_ff + (PtrW+1)'(done_x) - (PtrW+1)'(pop);
         cred_ff <= cred_ff - (PtrW+1)'(acc) + (PtrW+1)'(pop);
      end
   end

   `TSM_ASSERT(a_lanes, clock, reset, done_x == done_y, "axis chains out of step")
   `TSM_ASSERT(a_nover, clock, reset, !(done_x && cnt_q_ff == (PtrW+1)'(Depth) && !pop),
      "result FIFO overflow")
   `TSM_ASSERT(a_cred, clock, reset, cred_ff <= (PtrW+1)'(Depth), "credit count overrun")
endmodule
